[design/su2ar_pkg.sv]
// ---------------------------------------------------------------------------
// su2ar_pkg: shared types and constants for the SU(2) adjoint rotation
// Widths of the pipeline payloads, stage control and output limits.
// ---------------------------------------------------------------------------
package su2ar_pkg;

   // field widths
   localparam int VW   = 16;            // quaternion component, Q1.15
   localparam int EW   = 24;            // algebra vector component
   localparam int OW   = 24;            // rotated component
   localparam int PW   = 32;            // product of two quaternion components
   localparam int CW   = PW + 1;        // rotation-matrix coefficient
   localparam int MW   = EW + CW;       // coefficient times vector component
   localparam int AW   = MW + 1;        // sum of three terms, cross terms doubled
   localparam int FRAC = 30;            // fraction bits of the sum
   localparam int QW   = AW - FRAC;     // sum after dropping the fraction

   // rounding offset: one half at the scale of the sum
   localparam logic signed [AW-1:0] ROUND_HALF = AW'(1) << (FRAC - 1);

   // output rails
   localparam logic signed [OW-1:0] OUT_MAX = {1'b0, {(OW-1){1'b1}}};
   localparam logic signed [OW-1:0] OUT_MIN = {1'b1, {(OW-1){1'b0}}};

   // per-stage control: load enable and incoming valid
   typedef struct packed {
      logic load;
      logic valid;
   } stage_ctl_type;

   // request as taken from the ports
   typedef struct packed {
      logic                   cmd;
      logic signed [VW-1:0]   v_a;
      logic signed [VW-1:0]   v_b;
      logic signed [VW-1:0]   v_c;
      logic signed [VW-1:0]   v_d;
      logic signed [EW-1:0]   e_x;
      logic signed [EW-1:0]   e_y;
      logic signed [EW-1:0]   e_z;
   } req_type;

   // stage 1: pairwise quaternion products
   typedef struct packed {
      logic                   cmd;
      logic signed [PW-1:0]   aa;
      logic signed [PW-1:0]   bb;
      logic signed [PW-1:0]   cc;
      logic signed [PW-1:0]   dd;
      logic signed [PW-1:0]   ab;
      logic signed [PW-1:0]   ac;
      logic signed [PW-1:0]   bc;
      logic signed [PW-1:0]   ad;
      logic signed [PW-1:0]   bd;
      logic signed [PW-1:0]   cd;
      logic signed [EW-1:0]   e_x;
      logic signed [EW-1:0]   e_y;
      logic signed [EW-1:0]   e_z;
   } prod_type;

   // stage 2: rotation-matrix coefficients (cross terms not yet doubled)
   typedef struct packed {
      logic signed [CW-1:0]   xx;
      logic signed [CW-1:0]   yy;
      logic signed [CW-1:0]   zz;
      logic signed [CW-1:0]   k_xy;
      logic signed [CW-1:0]   k_xz;
      logic signed [CW-1:0]   k_yx;
      logic signed [CW-1:0]   k_yz;
      logic signed [CW-1:0]   k_zx;
      logic signed [CW-1:0]   k_zy;
      logic signed [EW-1:0]   e_x;
      logic signed [EW-1:0]   e_y;
      logic signed [EW-1:0]   e_z;
   } coef_type;

   // stage 3: the nine coefficient products
   typedef struct packed {
      logic signed [MW-1:0]   t_xx;
      logic signed [MW-1:0]   t_xy;
      logic signed [MW-1:0]   t_xz;
      logic signed [MW-1:0]   t_yy;
      logic signed [MW-1:0]   t_yx;
      logic signed [MW-1:0]   t_yz;
      logic signed [MW-1:0]   t_zz;
      logic signed [MW-1:0]   t_zx;
      logic signed [MW-1:0]   t_zy;
   } term_type;

   // stage 4: rounded sums at scale 2^30
   typedef struct packed {
      logic signed [AW-1:0]   acc_x;
      logic signed [AW-1:0]   acc_y;
      logic signed [AW-1:0]   acc_z;
   } acc_type;

   // stage 5: response
   typedef struct packed {
      logic signed [OW-1:0]   r_x;
      logic signed [OW-1:0]   r_y;
      logic signed [OW-1:0]   r_z;
      logic                   clipped;
   } rsp_type;

endpackage

[design/su2ar_prod.sv]
// ---------------------------------------------------------------------------
// su2ar_prod: pipeline stage 1
// Forms the ten pairwise products of the quaternion components.
// ---------------------------------------------------------------------------
module su2ar_prod (
   input  logic                      clock,
   input  logic                      reset,
   input  su2ar_pkg::stage_ctl_type  ctl,
   input  su2ar_pkg::req_type        req,
   output logic                      valid_ff,
   output su2ar_pkg::prod_type       prod_ff
);
   import su2ar_pkg::*;

   prod_type prod_in;

   // 16x16 signed products, exact in 32 bits
   always_comb begin
      prod_in.cmd = req.cmd;
      prod_in.aa  = PW'(req.v_a) * PW'(req.v_a);
      prod_in.bb  = PW'(req.v_b) * PW'(req.v_b);
      prod_in.cc  = PW'(req.v_c) * PW'(req.v_c);
      prod_in.dd  = PW'(req.v_d) * PW'(req.v_d);
      prod_in.ab  = PW'(req.v_a) * PW'(req.v_b);
      prod_in.ac  = PW'(req.v_a) * PW'(req.v_c);
      prod_in.bc  = PW'(req.v_b) * PW'(req.v_c);
      prod_in.ad  = PW'(req.v_a) * PW'(req.v_d);
      prod_in.bd  = PW'(req.v_b) * PW'(req.v_d);
      prod_in.cd  = PW'(req.v_c) * PW'(req.v_d);
      prod_in.e_x = req.e_x;
      prod_in.e_y = req.e_y;
      prod_in.e_z = req.e_z;
   end

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.load) begin
         valid_ff <= ctl.valid;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (ctl.load && ctl.valid) begin
         prod_ff <= prod_in;
      end
   end

endmodule

[design/su2ar_coef.sv]
// ---------------------------------------------------------------------------
// su2ar_coef: pipeline stage 2
// Combines the products into the nine rotation-matrix coefficients; cmd
// selects the sign of the cross terms.
// ---------------------------------------------------------------------------
module su2ar_coef (
   input  logic                      clock,
   input  logic                      reset,
   input  su2ar_pkg::stage_ctl_type  ctl,
   input  su2ar_pkg::prod_type       prod,
   output logic                      valid_ff,
   output su2ar_pkg::coef_type       coef_ff
);
   import su2ar_pkg::*;

   coef_type             coef_in;
   logic signed [CW-1:0] aa, bb, cc, dd, ab, ac, bc, ad, bd, cd;

   // widen once, then add
   always_comb begin
      aa = CW'(prod.aa);
      bb = CW'(prod.bb);
      cc = CW'(prod.cc);
      dd = CW'(prod.dd);
      ab = CW'(prod.ab);
      ac = CW'(prod.ac);
      bc = CW'(prod.bc);
      ad = CW'(prod.ad);
      bd = CW'(prod.bd);
      cd = CW'(prod.cd);

      coef_in.xx = aa - bb - cc + dd;
      coef_in.yy = bb - cc - aa + dd;
      coef_in.zz = cc - aa - bb + dd;

      // cmd high flips the sign of the scalar-part terms
      if (prod.cmd) begin
         coef_in.k_xy = ab - cd;
         coef_in.k_xz = ac + bd;
         coef_in.k_yx = ab + cd;
         coef_in.k_yz = bc - ad;
         coef_in.k_zx = ac - bd;
         coef_in.k_zy = bc + ad;
      end else begin
         coef_in.k_xy = ab + cd;
         coef_in.k_xz = ac - bd;
         coef_in.k_yx = ab - cd;
         coef_in.k_yz = bc + ad;
         coef_in.k_zx = ac + bd;
         coef_in.k_zy = bc - ad;
      end

      coef_in.e_x = prod.e_x;
      coef_in.e_y = prod.e_y;
      coef_in.e_z = prod.e_z;
   end

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.load) begin
         valid_ff <= ctl.valid;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (ctl.load && ctl.valid) begin
         coef_ff <= coef_in;
      end
   end

endmodule

[design/su2ar_mul.sv]
// ---------------------------------------------------------------------------
// su2ar_mul: pipeline stage 3
// Nine 24x33 signed multiplies of vector components by coefficients.
// ---------------------------------------------------------------------------
module su2ar_mul (
   input  logic                      clock,
   input  logic                      reset,
   input  su2ar_pkg::stage_ctl_type  ctl,
   input  su2ar_pkg::coef_type       coef,
   output logic                      valid_ff,
   output su2ar_pkg::term_type       term_ff
);
   import su2ar_pkg::*;

   term_type term_in;

   // one multiplier per matrix entry
   always_comb begin
      term_in.t_xx = MW'(coef.e_x) * MW'(coef.xx);
      term_in.t_xy = MW'(coef.e_y) * MW'(coef.k_xy);
      term_in.t_xz = MW'(coef.e_z) * MW'(coef.k_xz);
      term_in.t_yy = MW'(coef.e_y) * MW'(coef.yy);
      term_in.t_yx = MW'(coef.e_x) * MW'(coef.k_yx);
      term_in.t_yz = MW'(coef.e_z) * MW'(coef.k_yz);
      term_in.t_zz = MW'(coef.e_z) * MW'(coef.zz);
      term_in.t_zx = MW'(coef.e_x) * MW'(coef.k_zx);
      term_in.t_zy = MW'(coef.e_y) * MW'(coef.k_zy);
   end

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.load) begin
         valid_ff <= ctl.valid;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (ctl.load && ctl.valid) begin
         term_ff <= term_in;
      end
   end

endmodule

[design/su2ar_sum.sv]
// ---------------------------------------------------------------------------
// su2ar_sum: pipeline stage 4
// Adds the diagonal term to the doubled cross terms plus the rounding half.
// ---------------------------------------------------------------------------
module su2ar_sum (
   input  logic                      clock,
   input  logic                      reset,
   input  su2ar_pkg::stage_ctl_type  ctl,
   input  su2ar_pkg::term_type       term,
   output logic                      valid_ff,
   output su2ar_pkg::acc_type        acc_ff
);
   import su2ar_pkg::*;

   acc_type acc_in;

   // exact sums, well inside 58 bits
   always_comb begin
      acc_in.acc_x = AW'(term.t_xx) + ((AW'(term.t_xy) + AW'(term.t_xz)) <<< 1)
                     + ROUND_HALF;
      acc_in.acc_y = AW'(term.t_yy) + ((AW'(term.t_yx) + AW'(term.t_yz)) <<< 1)
                     + ROUND_HALF;
      acc_in.acc_z = AW'(term.t_zz) + ((AW'(term.t_zx) + AW'(term.t_zy)) <<< 1)
                     + ROUND_HALF;
   end

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.load) begin
         valid_ff <= ctl.valid;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (ctl.load && ctl.valid) begin
         acc_ff <= acc_in;
      end
   end

endmodule

[design/su2ar_sat.sv]
// ---------------------------------------------------------------------------
// su2ar_sat: pipeline stage 5, response register
// Drops the fraction (floor), saturates to 24 bits and flags any clip.
// ---------------------------------------------------------------------------
module su2ar_sat (
   input  logic                      clock,
   input  logic                      reset,
   input  su2ar_pkg::stage_ctl_type  ctl,
   input  su2ar_pkg::acc_type        acc,
   output logic                      valid_ff,
   output su2ar_pkg::rsp_type        rsp_ff
);
   import su2ar_pkg::*;

   rsp_type              rsp_in;
   logic signed [QW-1:0] q_x, q_y, q_z;
   logic                 ovf_x, ovf_y, ovf_z;

   // out of range when the output sign bit and the bits above it disagree
   function automatic logic ovf_of(input logic signed [QW-1:0] q);
      return !((&q[QW-1:OW-1]) || !(|q[QW-1:OW-1]));
   endfunction

   function automatic logic signed [OW-1:0] clamp(input logic signed [QW-1:0] q,
                                                  input logic ovf);
      logic signed [OW-1:0] r;
      if (!ovf) begin
         r = q[OW-1:0];
      end else if (q[QW-1]) begin
         r = OUT_MIN;
      end else begin
         r = OUT_MAX;
      end
      return r;
   endfunction

   // floor by dropping fraction bits, then clamp
   always_comb begin
      q_x   = acc.acc_x[AW-1:FRAC];
      q_y   = acc.acc_y[AW-1:FRAC];
      q_z   = acc.acc_z[AW-1:FRAC];
      ovf_x = ovf_of(q_x);
      ovf_y = ovf_of(q_y);
      ovf_z = ovf_of(q_z);
      rsp_in.r_x     = clamp(q_x, ovf_x);
      rsp_in.r_y     = clamp(q_y, ovf_y);
      rsp_in.r_z     = clamp(q_z, ovf_z);
      rsp_in.clipped = ovf_x || ovf_y || ovf_z;
   end

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.load) begin
         valid_ff <= ctl.valid;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (ctl.load && ctl.valid) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

[design/su2_adjoint_rotation_top.sv]
// ---------------------------------------------------------------------------
// su2_adjoint_rotation_top: SU(2) adjoint rotation of an algebra vector
// Five-stage pipeline: products, coefficients, multiplies, sum, saturate.
// ---------------------------------------------------------------------------
// Rotates E by V E V-dagger (cmd 0) or V-dagger E V (cmd 1), V a Q1.15
// quaternion, E three signed 24-bit components. Accepts one request per
// cycle while req_stall is low; responses pass through the five register
// stages (products, coefficients, multiplies, sum, saturate) in order,
// each holding its own valid bit; a stall on the response side fills empty
// stages first and only then stalls the request side. Results are rounded
// half up and saturated to 24 bits, with clipped set on any saturation.
module su2_adjoint_rotation_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_cmd,
   input  logic signed [15:0]  req_v_a,
   input  logic signed [15:0]  req_v_b,
   input  logic signed [15:0]  req_v_c,
   input  logic signed [15:0]  req_v_d,
   input  logic signed [23:0]  req_e_x,
   input  logic signed [23:0]  req_e_y,
   input  logic signed [23:0]  req_e_z,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [23:0]  rsp_r_x,
   output logic signed [23:0]  rsp_r_y,
   output logic signed [23:0]  rsp_r_z,
   output logic                rsp_clipped
);
   import su2ar_pkg::*;

   req_type       req;
   prod_type      prod;
   coef_type      coef;
   term_type      term;
   acc_type       acc;
   rsp_type       rsp;
   logic          v1, v2, v3, v4, v5;
   logic          rdy1, rdy2, rdy3, rdy4, rdy5;
   stage_ctl_type ctl1, ctl2, ctl3, ctl4, ctl5;

   // request bundle
   always_comb begin
      req.cmd = req_cmd;
      req.v_a = req_v_a;
      req.v_b = req_v_b;
      req.v_c = req_v_c;
      req.v_d = req_v_d;
      req.e_x = req_e_x;
      req.e_y = req_e_y;
      req.e_z = req_e_z;
   end

   // a stage can load when it is empty or its contents move on
   always_comb begin
      rdy5 = !v5 || !rsp_stall;
      rdy4 = !v4 || rdy5;
      rdy3 = !v3 || rdy4;
      rdy2 = !v2 || rdy3;
      rdy1 = !v1 || rdy2;
      ctl1 = '{load: rdy1, valid: req_valid};
      ctl2 = '{load: rdy2, valid: v1};
      ctl3 = '{load: rdy3, valid: v2};
      ctl4 = '{load: rdy4, valid: v3};
      ctl5 = '{load: rdy5, valid: v4};
   end

   assign req_stall = !rdy1;

   su2ar_prod u_prod (
      .clock(clock), .reset(reset), .ctl(ctl1), .req(req),
      .valid_ff(v1), .prod_ff(prod)
   );

   su2ar_coef u_coef (
      .clock(clock), .reset(reset), .ctl(ctl2), .prod(prod),
      .valid_ff(v2), .coef_ff(coef)
   );

   su2ar_mul u_mul (
      .clock(clock), .reset(reset), .ctl(ctl3), .coef(coef),
      .valid_ff(v3), .term_ff(term)
   );

   su2ar_sum u_sum (
      .clock(clock), .reset(reset), .ctl(ctl4), .term(term),
      .valid_ff(v4), .acc_ff(acc)
   );

   su2ar_sat u_sat (
      .clock(clock), .reset(reset), .ctl(ctl5), .acc(acc),
      .valid_ff(v5), .rsp_ff(rsp)
   );

   // response ports
   assign rsp_valid   = v5;
   assign rsp_r_x     = rsp.r_x;
   assign rsp_r_y     = rsp.r_y;
   assign rsp_r_z     = rsp.r_z;
   assign rsp_clipped = rsp.clipped;

`ifndef SYNTHESIS
   // with the output free the whole pipe advances
   a_free_flow: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("request stalled while response side is free");

   // request side only stalls when the first stage holds a request
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> v1)
      else $error("request stalled with empty first stage");

   // a sum moving into the output stage shows up as a response
   a_last_move: assert property (@(posedge clock) disable iff (reset)
      v4 && rdy5 |=> rsp_valid)
      else $error("sum lost on way to response register");

   // a clip flag means some component sits on a rail
   a_clip_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |->
         (rsp_r_x == OUT_MAX || rsp_r_x == OUT_MIN ||
          rsp_r_y == OUT_MAX || rsp_r_y == OUT_MIN ||
          rsp_r_z == OUT_MAX || rsp_r_z == OUT_MIN))
      else $error("clipped set with no saturated component");
`endif

endmodule
